@@ src/sbl_pkg.sv @@
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types and codes for the sorted byte list unit.
// ----------------------------------------------------------------------------
package sbl_pkg;

    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // result of the shared byte comparator
    typedef struct packed {
        logic ge;   // stored byte >= key
        logic eq;   // stored byte == key
    } cmp_t;

endpackage

@@ src/sbl_cmp.sv @@
// ----------------------------------------------------------------------------
// sbl_cmp
// Shared unsigned byte comparator used by every scan step.
// ----------------------------------------------------------------------------
module sbl_cmp (
    input  logic [sbl_pkg::VALUE_W-1:0] entry,
    input  logic [sbl_pkg::VALUE_W-1:0] key,
    output sbl_pkg::cmp_t               result
);

    always_comb
    begin
        result.ge = (entry >= key);
        result.eq = (entry == key);
    end

endmodule

@@ src/sbl_store.sv @@
// ----------------------------------------------------------------------------
// sbl_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbl_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [sbl_pkg::VALUE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic [sbl_pkg::VALUE_W-1:0] rd_data
);

    logic [sbl_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [sbl_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/sorted_byte_list_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_byte_list_unit
// Bounded list of bytes kept in ascending order, with insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, fields op and value) takes one
//   request word; op 0 inserts value, op 1 deletes its first copy.
//   Output channel (out_valid / out_stall) gives one result word per
//   request: status, count after the request, smallest held value and
//   head_valid.
//   Each request is worked by a small sequencer that walks the entry
//   memory one entry at a time: a registered read, then compare and
//   shift-write through the shared comparator. The longest request is a
//   delete that scans a full list. One request is in work at a time;
//   in_stall is high from the cycle after accept until the result word is
//   loaded, so the next request can be taken as that word first shows.
//   A finished result sits in the output register; the next request is
//   taken while it waits, and the sequencer holds at its last step if the
//   receiver still stalls the previous word.
//   Reset empties the list (count goes to zero) and drops any pending
//   result; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_byte_list_unit #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [sbl_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sbl_pkg::STATUS_W-1:0] status,
    output logic [sbl_pkg::COUNT_W-1:0]  count,
    output logic [sbl_pkg::VALUE_W-1:0]  head_value,
    output logic                         head_valid
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_PLACE = 6'b001000,
        S_HREAD = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            ptr_reg, ptr_next;
    logic                        found_reg, found_next;
    logic                        op_reg, op_next;
    logic [sbl_pkg::VALUE_W-1:0] value_reg, value_next;
    sbl_pkg::status_t            status_reg, status_next;

    // output word register
    logic                        out_valid_reg, out_valid_next;
    sbl_pkg::status_t            out_status_reg, out_status_next;
    logic [CNT_W-1:0]            out_count_reg, out_count_next;
    logic [sbl_pkg::VALUE_W-1:0] out_head_reg, out_head_next;
    logic                        out_hvalid_reg, out_hvalid_next;

    // memory port
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [sbl_pkg::VALUE_W-1:0] wr_data;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic [sbl_pkg::VALUE_W-1:0] rd_data;

    sbl_pkg::cmp_t               cmp;
    logic                        in_accept;
    logic                        out_free;
    logic                        last_entry;
    logic [31:0]                 count_ext;

    sbl_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sbl_cmp u_cmp (
        .entry  (rd_data),
        .key    (value_reg),
        .result (cmp)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    // delete scan reached the top held entry
    assign last_entry = ((CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        found_next      = found_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_head_next   = out_head_reg;
        out_hvalid_next = out_hvalid_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg;

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = op;
                    value_next = value;
                    found_next = 1'b0;
                    if (op == sbl_pkg::OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = sbl_pkg::ST_FULL;
                            state_next  = S_HREAD;
                        end
                        else if (count_reg == '0)
                        begin
                            ptr_next   = '0;
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            // walk down from the top, shifting entries >= value up
                            ptr_next   = count_reg[IDX_W-1:0];
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = sbl_pkg::ST_EMPTY;
                            state_next  = S_HREAD;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            state_next = S_READ;
                        end
                    end
                end
            end

            S_READ:
            begin
                rd_en = 1'b1;
                if (op_reg == sbl_pkg::OP_INSERT)
                begin
                    rd_addr = IDX_W'(ptr_reg - IDX_W'(1));
                end
                else
                begin
                    rd_addr = ptr_reg;
                end
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (op_reg == sbl_pkg::OP_INSERT)
                begin
                    wr_en = 1'b1;
                    if (cmp.ge)
                    begin
                        // move entry up one slot
                        wr_data  = rd_data;
                        ptr_next = IDX_W'(ptr_reg - IDX_W'(1));
                        if (ptr_reg == IDX_W'(1))
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        wr_data     = value_reg;
                        count_next  = CNT_W'(count_reg + CNT_W'(1));
                        status_next = sbl_pkg::ST_INSERTED;
                        state_next  = S_HREAD;
                    end
                end
                else
                begin
                    // after the match, close the gap by shifting down
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(ptr_reg - IDX_W'(1));
                        wr_data = rd_data;
                    end
                    found_next = found_reg || cmp.eq;
                    if (last_entry)
                    begin
                        if (found_reg || cmp.eq)
                        begin
                            count_next  = CNT_W'(count_reg - CNT_W'(1));
                            status_next = sbl_pkg::ST_DELETED;
                        end
                        else
                        begin
                            status_next = sbl_pkg::ST_NOT_FOUND;
                        end
                        state_next = S_HREAD;
                    end
                    else
                    begin
                        ptr_next   = IDX_W'(ptr_reg + IDX_W'(1));
                        state_next = S_READ;
                    end
                end
            end

            S_PLACE:
            begin
                wr_en       = 1'b1;
                wr_addr     = ptr_reg;
                wr_data     = value_reg;
                count_next  = CNT_W'(count_reg + CNT_W'(1));
                status_next = sbl_pkg::ST_INSERTED;
                state_next  = S_HREAD;
            end

            S_HREAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hold until the previous word has left
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = count_reg;
                    out_hvalid_next = (count_reg != '0);
                    out_head_next   = (count_reg != '0) ? rd_data : '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        op_reg         <= op_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_head_reg   <= out_head_next;
        out_hvalid_reg <= out_hvalid_next;
    end

    assign count_ext  = 32'(out_count_reg);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign count      = count_ext[sbl_pkg::COUNT_W-1:0];
    assign head_value = out_head_reg;
    assign head_valid = out_hvalid_reg;

endmodule

@@ src/sbl_checker.sv @@
// ----------------------------------------------------------------------------
// sbl_checker
// Port-level checks for the sorted byte list unit, bound to the top level.
// ----------------------------------------------------------------------------
module sbl_checker #(
    parameter int DEPTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [sbl_pkg::STATUS_W-1:0] status,
    input logic [sbl_pkg::COUNT_W-1:0]  count,
    input logic [sbl_pkg::VALUE_W-1:0]  head_value,
    input logic                         head_valid
);

    localparam logic [31:0] DEPTH_W = 32'(DEPTH);

    // hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(count))
        else $error("output word changed while stalled");

    a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_valid == (count != '0)) || (DEPTH > 31))
        else $error("head_valid disagrees with count");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_valid |-> head_value == '0)
        else $error("head_value not zero on empty list");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sbl_pkg::ST_FULL |-> count == DEPTH_W[sbl_pkg::COUNT_W-1:0])
        else $error("full status with count below depth");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sbl_pkg::ST_EMPTY |-> count == '0 && !head_valid)
        else $error("empty status with entries held");

endmodule

bind sorted_byte_list_unit sbl_checker #(
    .DEPTH (DEPTH)
) u_sbl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .count      (count),
    .head_value (head_value),
    .head_valid (head_valid)
);
